// ----- rtl/bcz_pkg.sv -----
// ----------------------------------------------------------------------------
// bcz_pkg: shared types and table for the bytewise checksum unit
// Holds the item structs passed between stages and the 256-word checksum
// table (reflected CRC-32 table with entry zero replaced).
// ----------------------------------------------------------------------------
`default_nettype none

package bcz_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CRC_W   = 32;
   localparam int unsigned COUNT_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic              restart;
      logic [BYTE_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] byte_count_out;
      logic [CRC_W-1:0]   crc_out;
   } rsp_item_type;

   localparam logic [CRC_W-1:0] CRC_WORDS [256] = '{
      32'h7fffffff,
      32'h77073096, 32'hee0e612c, 32'h990951ba, 32'h076dc419, 32'h706af48f,
      32'he963a535, 32'h9e6495a3, 32'h0edb8832, 32'h79dcb8a4, 32'he0d5e91e,
      32'h97d2d988, 32'h09b64c2b, 32'h7eb17cbd, 32'he7b82d07, 32'h90bf1d91,
      32'h1db71064, 32'h6ab020f2, 32'hf3b97148, 32'h84be41de, 32'h1adad47d,
      32'h6ddde4eb, 32'hf4d4b551, 32'h83d385c7, 32'h136c9856, 32'h646ba8c0,
      32'hfd62f97a, 32'h8a65c9ec, 32'h14015c4f, 32'h63066cd9, 32'hfa0f3d63,
      32'h8d080df5, 32'h3b6e20c8, 32'h4c69105e, 32'hd56041e4, 32'ha2677172,
      32'h3c03e4d1, 32'h4b04d447, 32'hd20d85fd, 32'ha50ab56b, 32'h35b5a8fa,
      32'h42b2986c, 32'hdbbbc9d6, 32'hacbcf940, 32'h32d86ce3, 32'h45df5c75,
      32'hdcd60dcf, 32'habd13d59, 32'h26d930ac, 32'h51de003a, 32'hc8d75180,
      32'hbfd06116, 32'h21b4f4b5, 32'h56b3c423, 32'hcfba9599, 32'hb8bda50f,
      32'h2802b89e, 32'h5f058808, 32'hc60cd9b2, 32'hb10be924, 32'h2f6f7c87,
      32'h58684c11, 32'hc1611dab, 32'hb6662d3d, 32'h76dc4190, 32'h01db7106,
      32'h98d220bc, 32'hefd5102a, 32'h71b18589, 32'h06b6b51f, 32'h9fbfe4a5,
      32'he8b8d433, 32'h7807c9a2, 32'h0f00f934, 32'h9609a88e, 32'he10e9818,
      32'h7f6a0dbb, 32'h086d3d2d, 32'h91646c97, 32'he6635c01, 32'h6b6b51f4,
      32'h1c6c6162, 32'h856530d8, 32'hf262004e, 32'h6c0695ed, 32'h1b01a57b,
      32'h8208f4c1, 32'hf50fc457, 32'h65b0d9c6, 32'h12b7e950, 32'h8bbeb8ea,
      32'hfcb9887c, 32'h62dd1ddf, 32'h15da2d49, 32'h8cd37cf3, 32'hfbd44c65,
      32'h4db26158, 32'h3ab551ce, 32'ha3bc0074, 32'hd4bb30e2, 32'h4adfa541,
      32'h3dd895d7, 32'ha4d1c46d, 32'hd3d6f4fb, 32'h4369e96a, 32'h346ed9fc,
      32'had678846, 32'hda60b8d0, 32'h44042d73, 32'h33031de5, 32'haa0a4c5f,
      32'hdd0d7cc9, 32'h5005713c, 32'h270241aa, 32'hbe0b1010, 32'hc90c2086,
      32'h5768b525, 32'h206f85b3, 32'hb966d409, 32'hce61e49f, 32'h5edef90e,
      32'h29d9c998, 32'hb0d09822, 32'hc7d7a8b4, 32'h59b33d17, 32'h2eb40d81,
      32'hb7bd5c3b, 32'hc0ba6cad, 32'hedb88320, 32'h9abfb3b6, 32'h03b6e20c,
      32'h74b1d29a, 32'head54739, 32'h9dd277af, 32'h04db2615, 32'h73dc1683,
      32'he3630b12, 32'h94643b84, 32'h0d6d6a3e, 32'h7a6a5aa8, 32'he40ecf0b,
      32'h9309ff9d, 32'h0a00ae27, 32'h7d079eb1, 32'hf00f9344, 32'h8708a3d2,
      32'h1e01f268, 32'h6906c2fe, 32'hf762575d, 32'h806567cb, 32'h196c3671,
      32'h6e6b06e7, 32'hfed41b76, 32'h89d32be0, 32'h10da7a5a, 32'h67dd4acc,
      32'hf9b9df6f, 32'h8ebeeff9, 32'h17b7be43, 32'h60b08ed5, 32'hd6d6a3e8,
      32'ha1d1937e, 32'h38d8c2c4, 32'h4fdff252, 32'hd1bb67f1, 32'ha6bc5767,
      32'h3fb506dd, 32'h48b2364b, 32'hd80d2bda, 32'haf0a1b4c, 32'h36034af6,
      32'h41047a60, 32'hdf60efc3, 32'ha867df55, 32'h316e8eef, 32'h4669be79,
      32'hcb61b38c, 32'hbc66831a, 32'h256fd2a0, 32'h5268e236, 32'hcc0c7795,
      32'hbb0b4703, 32'h220216b9, 32'h5505262f, 32'hc5ba3bbe, 32'hb2bd0b28,
      32'h2bb45a92, 32'h5cb36a04, 32'hc2d7ffa7, 32'hb5d0cf31, 32'h2cd99e8b,
      32'h5bdeae1d, 32'h9b64c2b0, 32'hec63f226, 32'h756aa39c, 32'h026d930a,
      32'h9c0906a9, 32'heb0e363f, 32'h72076785, 32'h05005713, 32'h95bf4a82,
      32'he2b87a14, 32'h7bb12bae, 32'h0cb61b38, 32'h92d28e9b, 32'he5d5be0d,
      32'h7cdcefb7, 32'h0bdbdf21, 32'h86d3d2d4, 32'hf1d4e242, 32'h68ddb3f8,
      32'h1fda836e, 32'h81be16cd, 32'hf6b9265b, 32'h6fb077e1, 32'h18b74777,
      32'h88085ae6, 32'hff0f6a70, 32'h66063bca, 32'h11010b5c, 32'h8f659eff,
      32'hf862ae69, 32'h616bffd3, 32'h166ccf45, 32'ha00ae278, 32'hd70dd2ee,
      32'h4e048354, 32'h3903b3c2, 32'ha7672661, 32'hd06016f7, 32'h4969474d,
      32'h3e6e77db, 32'haed16a4a, 32'hd9d65adc, 32'h40df0b66, 32'h37d83bf0,
      32'ha9bcae53, 32'hdebb9ec5, 32'h47b2cf7f, 32'h30b5ffe9, 32'hbdbdf21c,
      32'hcabac28a, 32'h53b39330, 32'h24b4a3a6, 32'hbad03605, 32'hcdd70693,
      32'h54de5729, 32'h23d967bf, 32'hb3667a2e, 32'hc4614ab8, 32'h5d681b02,
      32'h2a6f2b94, 32'hb40bbe37, 32'hc30c8ea1, 32'h5a05df1b, 32'h2d02ef8d
   };

endpackage

`default_nettype wire

// ----- rtl/bcz_in_stage.sv -----
// ----------------------------------------------------------------------------
// bcz_in_stage: input register
// Captures one item per cycle from the request channel while empty or
// draining, and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bcz_in_stage
   import bcz_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_item_type in_item,
   output logic              held_valid,
   output req_item_type      held_item,
   input  wire logic         advance
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // accept whenever the register is empty or drains this cycle
   assign in_ready   = !valid_ff || advance;
   assign valid_in   = in_valid ? 1'b1 : (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bcz_update.sv -----
// ----------------------------------------------------------------------------
// bcz_update: checksum state and per-byte update
// Keeps the running checksum, substitution index and byte count, and forms
// the next values for the held item in one pass through the table.
// ----------------------------------------------------------------------------
`default_nettype none

module bcz_update
   import bcz_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   logic [CRC_W-1:0]   crc_ff;
   logic [CRC_W-1:0]   crc_in;
   logic [BYTE_W-1:0]  sub_idx_ff;
   logic [BYTE_W-1:0]  sub_idx_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic [CRC_W-1:0]   base_crc;
   logic [BYTE_W-1:0]  base_sub;
   logic [COUNT_W-1:0] base_count;
   logic [BYTE_W-1:0]  raw_idx;
   logic [BYTE_W-1:0]  tbl_idx;

   always_comb begin
      // restart clears state ahead of this byte
      base_crc   = item.restart ? '0 : crc_ff;
      base_sub   = item.restart ? '0 : sub_idx_ff;
      base_count = item.restart ? '0 : count_ff;

      raw_idx = base_crc[CRC_W-1 -: BYTE_W] ^ item.data_byte;
      if (raw_idx == '0) begin
         tbl_idx    = base_sub;
         sub_idx_in = base_sub + 1'b1;
      end else begin
         tbl_idx    = raw_idx;
         sub_idx_in = base_sub;
      end

      crc_in   = {base_crc[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}} ^ CRC_WORDS[tbl_idx];
      count_in = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
   end

   assign result.crc_out        = crc_in;
   assign result.byte_count_out = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= '0;
         sub_idx_ff <= '0;
         count_ff   <= '0;
      end else if (advance) begin
         crc_ff     <= crc_in;
         sub_idx_ff <= sub_idx_in;
         count_ff   <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bcz_out_stage.sv -----
// ----------------------------------------------------------------------------
// bcz_out_stage: result register
// Holds one result item for the response channel and tells the input
// register when the held item may move forward.
// ----------------------------------------------------------------------------
`default_nettype none

module bcz_out_stage
   import bcz_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         held_valid,
   input  wire rsp_item_type result,
   output logic              advance,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   logic         room;

   // room when empty or the current item leaves this cycle
   assign room      = !valid_ff || out_ready;
   assign advance   = held_valid && room;
   assign valid_in  = advance ? 1'b1 : (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bytewise_crc32_zero_substitute_unit.sv -----
// ----------------------------------------------------------------------------
// bytewise_crc32_zero_substitute_unit: byte-serial table checksum
// Takes one byte per item on the req_ stream and returns the running 32-bit
// checksum and the saturating byte count on the rsp_ stream.
//
// Channels: req_tdata carries the byte, req_tuser the restart flag, which
// clears checksum, substitution index and count before its byte. rsp_tdata
// carries the checksum in the low word and the count in the high word.
// Path: an accepted item waits in the input register, then moves into the
// result register, which drives rsp_tvalid; while a result waits with
// rsp_tready low, the item stays in the input register.
// Throughput: one item per cycle while rsp_tready is high; the table lookup and XOR that
// feed the state registers fit between the input and result registers.
// Reset: all state and both stage valid flags clear; the next byte starts
// a fresh checksum.
// Stall: while rsp_tready is low the result holds; one more item may wait
// in the input register, after which req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module bytewise_crc32_zero_substitute_unit
   import bcz_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] restart
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // [31:0] crc_out, [63:32] byte_count_out
);

   req_item_type in_item;
   req_item_type held_item;
   rsp_item_type result;
   rsp_item_type out_item;
   logic         held_valid;
   logic         advance;

   assign in_item.data_byte = req_tdata;
   assign in_item.restart   = req_tuser;
   assign rsp_tdata         = {out_item.byte_count_out, out_item.crc_out};

   bcz_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .held_valid (held_valid),
      .held_item  (held_item),
      .advance    (advance)
   );

   bcz_update u_update (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .result  (result)
   );

   bcz_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .result     (result),
      .advance    (advance),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

endmodule

`default_nettype wire
